// File: rtl/sha_pkg.sv
// Shared types, constants and SHA-256 functions for the block compressor.
package sha_pkg;

  localparam int WORD_W       = 32;
  localparam int BLOCK_WORDS  = 16;
  localparam int DIGEST_WORDS = 8;
  localparam int ROUNDS       = 64;

  localparam logic CMD_CONTINUE = 1'b0;
  localparam logic CMD_RELOAD   = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_ROUND,
    ST_ADD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       shift_in;
    logic       first_word;
    logic       load_vars;
    logic       round_en;
    logic [5:0] rnd;
    logic       add_chain;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_busy;
  } dp_stat_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0:    h = 32'h6a09e667;
      3'd1:    h = 32'hbb67ae85;
      3'd2:    h = 32'h3c6ef372;
      3'd3:    h = 32'ha54ff53a;
      3'd4:    h = 32'h510e527f;
      3'd5:    h = 32'h9b05688c;
      3'd6:    h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t small_s0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_s0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

// File: rtl/sha_ctrl.sv
// Sequencer for word loading, the 64 rounds and the chain update.
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sha_pkg::dp_stat_t stat,
  output sha_pkg::dp_cmd_t  cmd
);

  sha_pkg::state_t state_r, state_nxt;
  logic [3:0] word_cnt_r, word_cnt_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha_pkg::ST_LOAD;
      word_cnt_r <= '0;
      rnd_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      word_cnt_r <= word_cnt_nxt;
      rnd_r      <= rnd_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    word_cnt_nxt = word_cnt_r;
    rnd_nxt      = rnd_r;
    in_tready    = 1'b0;
    accept       = 1'b0;
    cmd          = '0;
    cmd.rnd      = rnd_r;
    cmd.first_word = (word_cnt_r == 4'd0);
    case (state_r)
      sha_pkg::ST_LOAD: begin
        in_tready    = 1'b1;
        accept       = in_tvalid;
        cmd.shift_in = accept;
        if (accept) begin
          word_cnt_nxt = word_cnt_r + 4'd1;
          if (word_cnt_r == 4'(sha_pkg::BLOCK_WORDS - 1)) begin
            state_nxt = sha_pkg::ST_START;
          end
        end
      end
      sha_pkg::ST_START: begin
        // hold until the previous digest has gone, the chain is read there
        rnd_nxt = '0;
        if (!stat.emit_busy) begin
          cmd.load_vars = 1'b1;
          state_nxt     = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'(sha_pkg::ROUNDS - 1)) begin
          state_nxt = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
        state_nxt     = sha_pkg::ST_LOAD;
      end
      default: begin
        state_nxt = sha_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/sha_dp.sv
// Schedule window, working variables, chain value and digest output register.
module sha_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::dp_cmd_t  cmd,
  output sha_pkg::dp_stat_t stat,
  input  logic              in_command,
  input  sha_pkg::word_t    in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::word_t    out_word,
  output logic [2:0]        out_index,
  output logic              out_last
);

  sha_pkg::word_t win_r   [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t win_nxt [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t v_r     [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t v_nxt   [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t chain_r   [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t chain_nxt [sha_pkg::DIGEST_WORDS];
  logic           reload_r, reload_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     out_idx_r, out_idx_nxt;
  sha_pkg::word_t sched_new, t1, t2, push_word;

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        chain_r[i] <= sha_pkg::init_hash(3'(i));
        v_r[i]     <= '0;
      end
      reload_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      chain_r     <= chain_nxt;
      v_r         <= v_nxt;
      reload_r    <= reload_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  always_comb begin
    // next schedule word W[t+16] from the window holding W[t..t+15]
    sched_new = sha_pkg::small_s1(win_r[14]) + win_r[9]
              + sha_pkg::small_s0(win_r[1]) + win_r[0];
    t1 = v_r[7] + sha_pkg::big_s1(v_r[4]) + sha_pkg::choose(v_r[4], v_r[5], v_r[6])
       + sha_pkg::round_k(cmd.rnd) + win_r[0];
    t2 = sha_pkg::big_s0(v_r[0]) + sha_pkg::majority(v_r[0], v_r[1], v_r[2]);
    push_word = cmd.shift_in ? in_word : sched_new;

    win_nxt = win_r;
    if (cmd.shift_in || cmd.round_en) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[sha_pkg::BLOCK_WORDS-1] = push_word;
    end

    // defer the reload to the start of compression, the chain may still be draining
    reload_nxt = reload_r;
    if (cmd.shift_in && cmd.first_word) begin
      reload_nxt = (in_command == sha_pkg::CMD_RELOAD);
    end else if (cmd.load_vars) begin
      reload_nxt = 1'b0;
    end

    v_nxt     = v_r;
    chain_nxt = chain_r;
    if (cmd.load_vars) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        v_nxt[i]     = reload_r ? sha_pkg::init_hash(3'(i)) : chain_r[i];
        chain_nxt[i] = reload_r ? sha_pkg::init_hash(3'(i)) : chain_r[i];
      end
    end else if (cmd.round_en) begin
      for (int i = 1; i < sha_pkg::DIGEST_WORDS; i++) begin
        v_nxt[i] = v_r[i-1];
      end
      v_nxt[4] = v_r[3] + t1;
      v_nxt[0] = t1 + t2;
    end else if (cmd.add_chain) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        chain_nxt[i] = chain_r[i] + v_r[i];
      end
    end

    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    if (cmd.add_chain) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = '0;
    end else if (out_valid_r && out_ready) begin
      out_idx_nxt = out_idx_r + 3'd1;
      if (out_idx_r == 3'(sha_pkg::DIGEST_WORDS - 1)) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  assign stat.emit_busy = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_word       = chain_r[out_idx_r];
  assign out_index      = out_idx_r;
  assign out_last       = (out_idx_r == 3'(sha_pkg::DIGEST_WORDS - 1));

endmodule

// File: rtl/sha256_block_compressor_top.sv
// SHA-256 block compressor: top level joining sequencer and datapath.
//
// Input stream: sixteen 32-bit words per padded 512-bit block, big-endian,
// in in_tdata. in_tuser on a block's first word selects the chain: 0 keeps
// the running value, 1 restarts from the standard initial hash. in_tuser on
// the other fifteen words is ignored.
// Output stream: after each block, eight chain words, most significant
// first, in out_tdata, with the word index in out_tuser and tlast on the
// eighth.
// Timing: words load at one per cycle while the block is loading. After the
// sixteenth word a set-up step, the 64 rounds at one per cycle through a single
// round unit, and a chain-update step follow. Words of the next block are
// taken only once the previous block has been compressed and added into the
// chain.
// The digest drains from the chain registers while the next block loads; if
// the receiver stalls, compression of that next block waits until the last
// digest word has gone, and no further words are taken meanwhile.
// Reset sets the chain to the initial hash and clears the word count and the
// output register.
module sha256_block_compressor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] message_word
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);

  sha_pkg::dp_cmd_t  cmd;
  sha_pkg::dp_stat_t stat;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_tuser),
    .in_word    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (out_tdata),
    .out_index  (out_tuser),
    .out_last   (out_tlast)
  );

  // chain must not be reloaded while a digest is still draining from it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_vars |-> !out_tvalid)
    else $error("working variables loaded while digest still draining");

  // a digest run always starts at word index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tuser == 3'd0))
    else $error("digest run did not start at index zero");

  // no input word is taken while the rounds run
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !in_tready)
    else $error("input ready during compression rounds");

  // a digest run is not cut short once it has started
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("digest run ended before the last word");

endmodule

// File: dv/sha_digest_check_pkg.sv
// Digest predictor and scoreboard for the SHA-256 block compressor bench.
`timescale 1ns / 100ps

package sha_digest_check_pkg;

  import sha_pkg::*;

  // Initial hash words, word 0 in the top bits
  localparam logic [8*32-1:0] IV_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants, round 0 in the top bits
  localparam logic [64*32-1:0] ROUND_CONSTS = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  class sha_chain_model;
    logic [31:0]  chain [8];
    logic [31:0]  block_words [16];
    int unsigned  fill;
    digest_beat_t digest_q [$];
    int unsigned  mismatches;
    int unsigned  digests_seen;

    function new();
      fill         = 0;
      mismatches   = 0;
      digests_seen = 0;
      restart_chain();
    endfunction

    function void restart_chain();
      for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[(7 - i) * 32 +: 32];
    endfunction

    function logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] msg_mix0(input logic [31:0] x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function logic [31:0] msg_mix1(input logic [31:0] x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] wt, t1, t2;
      w = block_words;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          // window slot t mod 16 still holds the word from sixteen rounds back
          wt = msg_mix1(w[(t - 2) % 16]) + w[(t - 7) % 16]
             + msg_mix0(w[(t - 15) % 16]) + w[t % 16];
          w[t % 16] = wt;
        end
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONSTS[(63 - t) * 32 +: 32] + wt;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Note one accepted message word; queue the eight digest words on block end
    function void note_word(input logic cmd, input logic [31:0] word);
      digest_beat_t beat;
      if (fill == 0 && cmd == CMD_RELOAD) restart_chain();
      block_words[fill] = word;
      fill = (fill + 1) % BLOCK_WORDS;
      if (fill != 0) return;
      compress_block();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        beat.word  = chain[i];
        beat.index = 3'(i);
        beat.last  = (i == DIGEST_WORDS - 1);
        digest_q.push_back(beat);
      end
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction

    function void log_fault(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Check one digest word against the oldest one outstanding
    function void check_digest(input logic [31:0] word, input logic [2:0] index,
                               input logic last);
      digest_beat_t want;
      digests_seen++;
      if (digest_q.size() == 0) begin
        log_fault($sformatf("unexpected digest word %h idx %0d last %0b",
                            word, index, last));
        return;
      end
      want = digest_q.pop_front();
      if (want.word !== word || want.index !== index || want.last !== last)
        log_fault($sformatf("digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                            want.word, want.index, want.last, word, index, last));
    endfunction
  endclass

endpackage

// File: dv/tb.sv
// Top-level bench: drives message blocks into the compressor and checks every digest word.
`timescale 1ns / 100ps

module tb;

  import sha_pkg::*;
  import sha_digest_check_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RAND_BLOCKS  = 21;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int TIMEOUT_NS   = 4_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  sha_chain_model sb = new();
  bit             calm = 1'b0;
  bit             held_off = 1'b0;

  sha256_block_compressor_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic cmd, input logic [31:0] word);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(cmd, word);
    @(negedge clk);
  endtask

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_block(input logic first_cmd);
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      // command is only looked at on the first word; toggle it elsewhere
      send_word((i == 0) ? first_cmd : logic'($urandom_range(0, 1)), pick_word());
      idle_in(pick_gap());
    end
  endtask

  // Receiver: random stalls, one long hold-off once digests are flowing
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.digests_seen >= 24) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_digest(out_tdata, out_tuser, out_tlast);
  end

  initial begin
    logic [31:0] edge_words [16];
    edge_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                   32'h7fff_ffff, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555,
                   32'h6162_6380, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
                   32'hdead_beef, 32'h0123_4567, 32'h89ab_cdef, 32'h0000_0018};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_CONTINUE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reload on the first word, then raise the command on all the others
    for (int i = 0; i < BLOCK_WORDS; i++)
      send_word((i == 0) ? CMD_RELOAD : CMD_RELOAD, edge_words[i]);
    idle_in(pick_gap());

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      calm = (blk >= 5 && blk <= 7);
      if (blk == 12) wait_drained();
      send_block(($urandom_range(0, 3) == 0) ? CMD_RELOAD : CMD_CONTINUE);
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("sha256_block_compressor_top regression: pass");
    end else begin
      $display("sha256_block_compressor_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sha256_block_compressor_top regression: fail");
    $finish;
  end

endmodule
